[rtl/cpot_pkg.sv]
// Shared constants, codes and word types of the convex polygon occlusion test.
package cpot_pkg;

    // coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int IN_W        = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int FRAC_BITS   = 28;

    // edge cross product widths: difference, product, z, z rescaled, compare
    localparam int DW  = IN_W + 1;
    localparam int PW  = 2 * DW;
    localparam int ZW  = PW + 1;
    localparam int ZSW = ZW - FRAC_BITS;
    localparam int ZCW = (ZSW > 33) ? ZSW : 33;

    // plane value widths: sum, rescaled, compare
    localparam int PLW = ((2 * IN_W > IN_W + FRAC_BITS) ? 2 * IN_W : IN_W + FRAC_BITS) + 2;
    localparam int PSW = PLW - FRAC_BITS;
    localparam int PCW = (PSW > 33) ? PSW : 33;

    // configuration
    localparam int CFG_W  = 32;
    localparam int TOL_W  = 31;
    localparam int ADDR_W = 3;
    localparam logic signed [CFG_W-1:0] MARGIN_RESET = -32'sd26844;
    localparam logic        [TOL_W-1:0] TOL_RESET    = 31'd2684;
    localparam logic REG_PLANE_MARGIN   = 1'b0;
    localparam logic REG_ZERO_TOLERANCE = 1'b1;

    // queues
    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
    localparam int RES_Q_DEPTH = 4;
    localparam int RES_Q_AW    = $clog2(RES_Q_DEPTH);

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_BOX    = 2'd1,
        OP_PLANE  = 2'd2,
        OP_VERTEX = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CAUSE_HIDDEN = 2'd0,
        CAUSE_BOX    = 2'd1,
        CAUSE_PLANE  = 2'd2,
        CAUSE_EDGE   = 2'd3
    } t_cause;

    typedef struct packed {
        t_op                    op;
        logic                   last;
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        logic signed [IN_W-1:0] c;
        logic signed [IN_W-1:0] d;
    } t_cmd;

    typedef struct packed {
        logic   visible;
        t_cause cause;
    } t_result;

endpackage

[rtl/cpot_front.sv]
// Input side: takes words, trims coordinates, classifies and queues them.
module cpot_front
    import cpot_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_field_a,
    input  logic [31:0] i_field_b,
    input  logic [31:0] i_field_c,
    input  logic [31:0] i_field_d,
    input  logic        i_last_vertex,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    t_cmd                mem [CMD_Q_DEPTH];
    logic [CMD_Q_AW-1:0] r_wr_ptr;
    logic [CMD_Q_AW-1:0] r_rd_ptr;
    logic [CMD_Q_AW:0]   r_count;
    logic [CMD_Q_AW:0]   n_count;
    t_cmd                cmd_in;
    logic                wr;
    logic                rd;

    // last flag only means something on a vertex word
    always_comb begin
        cmd_in.op   = t_op'(i_op);
        cmd_in.last = (t_op'(i_op) == OP_VERTEX) && i_last_vertex;
        cmd_in.a    = $signed(i_field_a[IN_W-1:0]);
        cmd_in.b    = $signed(i_field_b[IN_W-1:0]);
        cmd_in.c    = $signed(i_field_c[IN_W-1:0]);
        cmd_in.d    = $signed(i_field_d[IN_W-1:0]);
    end

    assign o_full      = (r_count == (CMD_Q_AW+1)'(CMD_Q_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign wr          = i_push && !o_full;
    assign rd          = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

[rtl/cpot_back.sv]
// Execution side: state registers, cross product and plane pipeline, verdict.
module cpot_back
    import cpot_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  t_cmd                    i_cmd,
    output logic                    o_cmd_pop,
    input  logic signed [CFG_W-1:0] i_plane_margin,
    input  logic        [TOL_W-1:0] i_zero_tol,
    input  logic                    i_res_full,
    output logic                    o_res_wr,
    output t_result                 o_res
);

    // loaded state
    logic signed [IN_W-1:0] r_qx, r_qy, r_qz;
    logic signed [IN_W-1:0] r_bx0, r_by0, r_bx1, r_by1;
    logic signed [IN_W-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [IN_W-1:0] r_fx, r_fy, r_px, r_py;
    logic                   r_seen;
    logic                   r_found;

    logic en;
    logic take;
    logic is_vtx;

    // stage 1 operands
    logic signed [DW-1:0]   n_ux, n_uy, n_vx, n_vy;
    logic signed [DW-1:0]   n_cux, n_cuy, n_cvx, n_cvy;
    logic signed [IN_W-1:0] fx_eff, fy_eff;
    logic                   n_box;

    logic                   r_s1_v, r_s1_last, r_s1_prev_ok, r_s1_box;
    logic signed [DW-1:0]   r_s1_ux, r_s1_uy, r_s1_vx, r_s1_vy;
    logic signed [DW-1:0]   r_s1_cux, r_s1_cuy, r_s1_cvx, r_s1_cvy;
    logic signed [IN_W-1:0] r_s1_a, r_s1_b, r_s1_c, r_s1_d;
    logic signed [IN_W-1:0] r_s1_x, r_s1_y, r_s1_z;

    logic                     r_s2_v, r_s2_last, r_s2_prev_ok, r_s2_box;
    logic signed [PW-1:0]     r_s2_p1, r_s2_p2, r_s2_p3, r_s2_p4;
    logic signed [2*IN_W-1:0] r_s2_ma, r_s2_mb, r_s2_mc;
    logic signed [PLW-1:0]    r_s2_dsh;

    logic                  r_s3_v, r_s3_last, r_s3_prev_ok, r_s3_box;
    logic signed [ZW-1:0]  r_s3_zp, r_s3_zc;
    logic signed [PLW-1:0] r_s3_pab, r_s3_pcd;

    logic                  r_s4_v, r_s4_last, r_s4_box, r_s4_prev_out, r_s4_close_out;
    logic signed [PLW-1:0] r_s4_pv;

    logic signed [ZCW-1:0] neg_tol;
    logic signed [ZCW-1:0] zp_sh, zc_sh;
    logic signed [PCW-1:0] pv_sh, margin_ext;
    logic                  plane_front;
    logic                  found_any;

    assign en        = !i_res_full;
    assign take      = en && i_cmd_valid;
    assign is_vtx    = (i_cmd.op == OP_VERTEX);
    assign o_cmd_pop = take;

    // edges prev->cur and, for the closing edge, cur->first
    always_comb begin
        fx_eff = r_seen ? r_fx : i_cmd.a;
        fy_eff = r_seen ? r_fy : i_cmd.b;
        n_ux   = DW'(i_cmd.a) - DW'(r_px);
        n_uy   = DW'(i_cmd.b) - DW'(r_py);
        n_vx   = DW'(r_qx) - DW'(i_cmd.a);
        n_vy   = DW'(r_qy) - DW'(i_cmd.b);
        n_cux  = DW'(fx_eff) - DW'(i_cmd.a);
        n_cuy  = DW'(fy_eff) - DW'(i_cmd.b);
        n_cvx  = DW'(r_qx) - DW'(fx_eff);
        n_cvy  = DW'(r_qy) - DW'(fy_eff);
        n_box  = (r_qx > r_bx1) || (r_qx < r_bx0) || (r_qy > r_by1) || (r_qy < r_by0);
    end

    // loaded state and stream flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx   <= '0;
            r_qy   <= '0;
            r_qz   <= '0;
            r_bx0  <= '0;
            r_by0  <= '0;
            r_bx1  <= '0;
            r_by1  <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_pc   <= '0;
            r_pd   <= '0;
            r_seen <= 1'b0;
        end else if (take) begin
            unique case (i_cmd.op)
                OP_POINT: begin
                    r_qx <= i_cmd.a;
                    r_qy <= i_cmd.b;
                    r_qz <= i_cmd.c;
                end
                OP_BOX: begin
                    r_bx0 <= i_cmd.a;
                    r_by0 <= i_cmd.b;
                    r_bx1 <= i_cmd.c;
                    r_by1 <= i_cmd.d;
                end
                OP_PLANE: begin
                    r_pa <= i_cmd.a;
                    r_pb <= i_cmd.b;
                    r_pc <= i_cmd.c;
                    r_pd <= i_cmd.d;
                end
                OP_VERTEX: begin
                    r_seen <= !i_cmd.last;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && is_vtx) begin
            r_px <= i_cmd.a;
            r_py <= i_cmd.b;
            if (!r_seen) begin
                r_fx <= i_cmd.a;
                r_fy <= i_cmd.b;
            end
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= take && is_vtx;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            // s1: differences, box test, plane snapshot
            r_s1_last    <= i_cmd.last;
            r_s1_prev_ok <= r_seen;
            r_s1_box     <= n_box;
            r_s1_ux      <= n_ux;
            r_s1_uy      <= n_uy;
            r_s1_vx      <= n_vx;
            r_s1_vy      <= n_vy;
            r_s1_cux     <= n_cux;
            r_s1_cuy     <= n_cuy;
            r_s1_cvx     <= n_cvx;
            r_s1_cvy     <= n_cvy;
            r_s1_a       <= r_pa;
            r_s1_b       <= r_pb;
            r_s1_c       <= r_pc;
            r_s1_d       <= r_pd;
            r_s1_x       <= r_qx;
            r_s1_y       <= r_qy;
            r_s1_z       <= r_qz;
            // s2: products
            r_s2_last    <= r_s1_last;
            r_s2_prev_ok <= r_s1_prev_ok;
            r_s2_box     <= r_s1_box;
            r_s2_p1      <= r_s1_ux * r_s1_vy;
            r_s2_p2      <= r_s1_uy * r_s1_vx;
            r_s2_p3      <= r_s1_cux * r_s1_cvy;
            r_s2_p4      <= r_s1_cuy * r_s1_cvx;
            r_s2_ma      <= r_s1_a * r_s1_x;
            r_s2_mb      <= r_s1_b * r_s1_y;
            r_s2_mc      <= r_s1_c * r_s1_z;
            r_s2_dsh     <= {{(PLW-IN_W-FRAC_BITS){r_s1_d[IN_W-1]}}, r_s1_d,
                             {FRAC_BITS{1'b0}}};
            // s3: z values, partial plane sums
            r_s3_last    <= r_s2_last;
            r_s3_prev_ok <= r_s2_prev_ok;
            r_s3_box     <= r_s2_box;
            r_s3_zp      <= ZW'(r_s2_p1) - ZW'(r_s2_p2);
            r_s3_zc      <= ZW'(r_s2_p3) - ZW'(r_s2_p4);
            r_s3_pab     <= PLW'(r_s2_ma) + PLW'(r_s2_mb);
            r_s3_pcd     <= PLW'(r_s2_mc) + r_s2_dsh;
            // s4: edge verdicts, plane sum
            r_s4_last      <= r_s3_last;
            r_s4_box       <= r_s3_box;
            r_s4_prev_out  <= r_s3_prev_ok && (zp_sh < neg_tol);
            r_s4_close_out <= r_s3_last && (zc_sh < neg_tol);
            r_s4_pv        <= r_s3_pab + r_s3_pcd;
        end
    end

    // rescale by floor shift, then compare against the registers
    always_comb begin
        neg_tol    = -ZCW'($signed({1'b0, i_zero_tol}));
        zp_sh      = ZCW'($signed(r_s3_zp[ZW-1:FRAC_BITS]));
        zc_sh      = ZCW'($signed(r_s3_zc[ZW-1:FRAC_BITS]));
        pv_sh      = PCW'($signed(r_s4_pv[PLW-1:FRAC_BITS]));
        margin_ext = PCW'(i_plane_margin);
    end

    assign plane_front = (pv_sh > margin_ext);
    assign found_any   = r_found || r_s4_prev_out || r_s4_close_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (en && r_s4_v) begin
            r_found <= r_s4_last ? 1'b0 : found_any;
        end
    end

    // box beats plane beats edge
    always_comb begin
        if (r_s4_box) begin
            o_res.cause = CAUSE_BOX;
        end else if (plane_front) begin
            o_res.cause = CAUSE_PLANE;
        end else if (found_any) begin
            o_res.cause = CAUSE_EDGE;
        end else begin
            o_res.cause = CAUSE_HIDDEN;
        end
        o_res.visible = (o_res.cause != CAUSE_HIDDEN);
    end

    assign o_res_wr = en && r_s4_v && r_s4_last;

endmodule

[rtl/cpot_out_q.sv]
// Verdict queue between the pipeline and the result ports.
module cpot_out_q
    import cpot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_res,
    input  logic    i_pop
);

    t_result             mem [RES_Q_DEPTH];
    logic [RES_Q_AW-1:0] r_wr_ptr;
    logic [RES_Q_AW-1:0] r_rd_ptr;
    logic [RES_Q_AW:0]   r_count;
    logic [RES_Q_AW:0]   n_count;
    logic                wr;
    logic                rd;

    assign o_full  = (r_count == (RES_Q_AW+1)'(RES_Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_wr && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_res   = mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

[rtl/convex_polygon_occlusion_test.sv]
// Top level of the convex polygon occlusion test: ports, registers, front and back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | push / full            | i_op, i_field_a..d, i_last_vertex
//  result   | pop / empty            | o_visible, o_cause
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
//  One word a cycle in, sustained while the result queue has room; every stage of the back
//  pipeline takes a word each cycle unless that queue is full. A verdict reaches the ports via
//  the command queue, four pipeline stages (differences, products, sums, compares), result queue.
//  Reset (synchronous, active low) empties both queues, clears the pipeline, the loaded
//  point, box and plane, and returns both registers to their reset values.
//  A full result queue freezes the whole back pipeline; the command queue keeps filling
//  until it too is full, and only then does full rise.
module convex_polygon_occlusion_test
    import cpot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input words
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_op,
    input  logic [31:0]       i_field_a,
    input  logic [31:0]       i_field_b,
    input  logic [31:0]       i_field_c,
    input  logic [31:0]       i_field_d,
    input  logic              i_last_vertex,
    // result words
    input  logic              pop,
    output logic              empty,
    output logic              o_visible,
    output logic [1:0]        o_cause,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    logic signed [CFG_W-1:0] r_plane_margin;
    logic        [TOL_W-1:0] r_zero_tol;
    logic                    cfg_wr;

    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    t_result res_in;
    t_result res_out;
    logic    res_wr;
    logic    res_full;

    // ---------------------------------------------------------------
    // Configuration: register i at byte address 4*i, so bit 2 picks it.
    // The user must write them only while idle (not enforced here), so the pipeline reads them live.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_margin <= MARGIN_RESET;
            r_zero_tol     <= TOL_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PLANE_MARGIN:   r_plane_margin <= $signed(pwdata);
                REG_ZERO_TOLERANCE: r_zero_tol     <= pwdata[TOL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PLANE_MARGIN:   prdata = r_plane_margin;
            REG_ZERO_TOLERANCE: prdata = {1'b0, r_zero_tol};
        endcase
    end

    // ---------------------------------------------------------------
    // Front: trims fields to the coordinate width, tags the op and
    // queues the word; full comes straight from the queue count.
    // ---------------------------------------------------------------
    cpot_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_field_a     (i_field_a),
        .i_field_b     (i_field_b),
        .i_field_c     (i_field_c),
        .i_field_d     (i_field_d),
        .i_last_vertex (i_last_vertex),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    // ---------------------------------------------------------------
    // Back: applies loads in order, forms both edge cross products and
    // the plane value, and writes a verdict on each last vertex.
    // ---------------------------------------------------------------
    cpot_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .i_plane_margin (r_plane_margin),
        .i_zero_tol     (r_zero_tol),
        .i_res_full     (res_full),
        .o_res_wr       (res_wr),
        .o_res          (res_in)
    );

    // ---------------------------------------------------------------
    // Result queue: decouples the consumer from the pipeline.
    // ---------------------------------------------------------------
    cpot_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .o_res   (res_out),
        .i_pop   (pop)
    );

    assign o_visible = res_out.visible;
    assign o_cause   = res_out.cause;

endmodule
